// ----- hw/rtl/rvme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvme_pkg: shared types and constants for the mini execute unit
// Word formats of both channels, operation codes and the internal port
// structs between the top level, the register file and the data memory.
// ----------------------------------------------------------------------------
package rvme_pkg;

  localparam int XLEN          = 32;
  localparam int RF_DEPTH      = 32;
  localparam int RIDX_W        = 5;
  localparam int MEM_WORDS_DEF = 1024;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_ADDI = 2'd1,
    OP_LW   = 2'd2,
    OP_SW   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [RIDX_W-1:0]       first_reg;
    logic [RIDX_W-1:0]       second_reg;
    logic [RIDX_W-1:0]       third_reg;
    logic signed [XLEN-1:0]  immediate;
  } in_word_t;

  typedef struct packed {
    logic signed [XLEN-1:0]  result_value;
    logic signed [XLEN-1:0]  mem_address;
    logic                    did_store;
  } out_word_t;

  typedef struct packed {
    logic              vld;
    logic [RIDX_W-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [XLEN-1:0] wdata;
  } dm_req_t;

endpackage

// ----- hw/rtl/rvme_regfile.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvme_regfile: 32 x 32 register file
// One write port and two registered read ports. A read that meets a write
// at the same edge returns the new data. An entry never written reads as
// its own index.
// ----------------------------------------------------------------------------
module rvme_regfile
  import rvme_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RIDX_W-1:0] ra_a,
  input  logic [RIDX_W-1:0] ra_b,
  input  rf_wr_t            wr,
  output logic [XLEN-1:0]   rd_a,
  output logic [XLEN-1:0]   rd_b
);

  logic [XLEN-1:0]     mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] wrt_r;
  logic [XLEN-1:0]     q_a_r;
  logic [XLEN-1:0]     q_b_r;
  logic [XLEN-1:0]     byp_r;
  logic                hit_a_r;
  logic                hit_b_r;
  logic                wrt_a_r;
  logic                wrt_b_r;
  logic [RIDX_W-1:0]   idx_a_r;
  logic [RIDX_W-1:0]   idx_b_r;

  always_ff @(posedge clk) begin
    if (wr.vld) begin
      mem[wr.idx] <= wr.data;
    end
    q_a_r <= mem[ra_a];
    q_b_r <= mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrt_r <= '0;
    end else if (wr.vld) begin
      wrt_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    hit_a_r <= wr.vld && (wr.idx == ra_a);
    hit_b_r <= wr.vld && (wr.idx == ra_b);
    byp_r   <= wr.data;
    wrt_a_r <= wrt_r[ra_a];
    wrt_b_r <= wrt_r[ra_b];
    idx_a_r <= ra_a;
    idx_b_r <= ra_b;
  end

  assign rd_a = hit_a_r ? byp_r : (wrt_a_r ? q_a_r : XLEN'(idx_a_r));
  assign rd_b = hit_b_r ? byp_r : (wrt_b_r ? q_b_r : XLEN'(idx_b_r));

endmodule

// ----- hw/rtl/rvme_dmem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvme_dmem: word data memory with clearing pass
// Single port memory with registered read data. After reset it writes zero
// to every word, one word per cycle, and reports busy meanwhile.
// ----------------------------------------------------------------------------
module rvme_dmem
  import rvme_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dm_req_t                      req,
  input  logic [$clog2(MEM_WORDS)-1:0] idx,
  output logic [XLEN-1:0]              rdata,
  output logic                         busy
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [XLEN-1:0] mem [MEM_WORDS];
  logic [XLEN-1:0] rdata_r;
  logic            clr_r;
  logic            clr_nxt;
  logic [AW-1:0]   cnt_r;
  logic [AW-1:0]   cnt_nxt;

  always_comb begin
    clr_nxt = clr_r;
    cnt_nxt = cnt_r;
    if (clr_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == AW'(MEM_WORDS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      cnt_r <= '0;
    end else begin
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[cnt_r] <= '0;
    end else if (req.wr_en) begin
      mem[idx] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[idx];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_r;

endmodule

// ----- hw/rtl/rv32_mini_execute_unit_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_mini_execute_unit_top: executes ADD, ADDI, LW and SW
// Keeps a 32-entry register file and a word data memory and returns one
// result word for every decoded instruction word it takes.
// ----------------------------------------------------------------------------
// The input channel takes one decoded instruction word per cycle, while
// in_stall is low, on in_valid/in_stall; the output channel returns one
// result word per instruction, in order, on out_valid/out_stall.
// An instruction passes four stages: operand read and add, word index
// multiply, index reduction with the data memory access, and the output
// register.
// Throughput is one instruction per cycle unless a stall or load hazard
// holds it. An instruction that reads the destination of a load still in
// the second or third stage waits in the first stage, since load data
// leaves the registered memory read only at the end of the third stage.
// After reset the register file reads as its index, and the data memory
// is cleared one word per cycle; in_stall stays high while it clears.
// When out_stall is high the output word holds and the stages behind it
// fill up; in_stall rises once the first stage cannot move on.
// ----------------------------------------------------------------------------
module rv32_mini_execute_unit_top
  import rvme_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int QW  = XLEN - 2;
  localparam int SH  = QW + AW;
  localparam int RW  = QW + 1;
  localparam int PW  = QW + RW;
  localparam int QTW = PW - SH;
  localparam logic [63:0] RECIP_L =
    ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
  localparam logic [RW-1:0] RECIP_C = RW'(RECIP_L);
  localparam logic [QW-1:0] MW_C    = QW'(MEM_WORDS);

  logic              s1_vld_r;
  op_t               s1_op_r;
  logic [RIDX_W-1:0] s1_rd_r;
  logic [RIDX_W-1:0] s1_rs_r;
  logic [RIDX_W-1:0] s1_rt_r;
  logic [XLEN-1:0]   s1_imm_r;

  logic              s2_vld_r;
  op_t               s2_op_r;
  logic [RIDX_W-1:0] s2_rd_r;
  logic [XLEN-1:0]   s2_val_r;
  logic [XLEN-1:0]   s2_addr_r;

  logic              s3_vld_r;
  op_t               s3_op_r;
  logic [RIDX_W-1:0] s3_rd_r;
  logic [XLEN-1:0]   s3_val_r;
  logic [XLEN-1:0]   s3_addr_r;
  logic [PW-1:0]     s3_prod_r;

  logic              out_vld_r;
  logic              out_ld_r;
  logic              out_st_r;
  logic [XLEN-1:0]   out_val_r;
  logic [XLEN-1:0]   out_addr_r;

  logic              wb_vld_r;
  logic              wb_ld_r;
  logic [RIDX_W-1:0] wb_idx_r;
  logic [XLEN-1:0]   wb_val_r;

  logic              in_acc;
  logic              clr_busy;
  logic              out_free;
  logic              s3_go;
  logic              s3_free;
  logic              s2_go;
  logic              s2_free;
  logic              s1_go;
  logic              s1_hold;
  logic              ld_haz;
  logic              need_b;
  logic [RIDX_W-1:0] s1_rb;
  logic [RIDX_W-1:0] in_rb;
  logic [RIDX_W-1:0] ra_a;
  logic [RIDX_W-1:0] ra_b;
  logic [XLEN-1:0]   raw_a;
  logic [XLEN-1:0]   raw_b;
  logic [XLEN-1:0]   opa;
  logic [XLEN-1:0]   opb;
  logic [XLEN-1:0]   sum_rr;
  logic [XLEN-1:0]   sum_ri;
  logic [XLEN-1:0]   s1_val;
  logic [XLEN-1:0]   s1_addr;
  logic [XLEN-1:0]   wb_data;
  logic [XLEN-1:0]   dm_rdata;
  logic [QW-1:0]     s2_q;
  logic [PW-1:0]     prod_nxt;
  logic [QW-1:0]     s3_q;
  logic [QTW-1:0]    quot;
  logic [QW-1:0]     rem;
  logic              s2_wr;
  logic              s3_wr;
  rf_wr_t            rf_wr;
  dm_req_t           dm_req;

  // Stage flow control; a load hazard holds the first stage and sends a bubble.
  assign out_free = !out_vld_r || !out_stall;
  assign s3_go    = s3_vld_r && out_free;
  assign s3_free  = !s3_vld_r || out_free;
  assign s2_go    = s2_vld_r && s3_free;
  assign s2_free  = !s2_vld_r || s3_free;
  assign s1_go    = s1_vld_r && s2_free && !ld_haz;
  assign s1_hold  = s1_vld_r && !s1_go;
  assign in_stall = clr_busy || s1_hold;
  assign in_acc   = in_valid && !in_stall;

  assign need_b = (s1_op_r == OP_ADD) || (s1_op_r == OP_SW);
  assign s1_rb  = (s1_op_r == OP_SW) ? s1_rd_r : s1_rt_r;
  assign in_rb  = (in_data.opcode == OP_SW) ? in_data.first_reg : in_data.third_reg;
  assign s2_wr  = s2_vld_r && (s2_op_r != OP_SW);
  assign s3_wr  = s3_vld_r && (s3_op_r != OP_SW);

  assign ld_haz =
    (s2_vld_r && (s2_op_r == OP_LW) &&
     ((s2_rd_r == s1_rs_r) || (need_b && (s2_rd_r == s1_rb)))) ||
    (s3_vld_r && (s3_op_r == OP_LW) &&
     ((s3_rd_r == s1_rs_r) || (need_b && (s3_rd_r == s1_rb))));

  // While the first stage holds, its operands are read again every cycle.
  assign ra_a = s1_hold ? s1_rs_r : in_data.second_reg;
  assign ra_b = s1_hold ? s1_rb : in_rb;

  assign wb_data    = wb_ld_r ? dm_rdata : wb_val_r;
  assign rf_wr.vld  = wb_vld_r;
  assign rf_wr.idx  = wb_idx_r;
  assign rf_wr.data = wb_data;

  rvme_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .ra_a  (ra_a),
    .ra_b  (ra_b),
    .wr    (rf_wr),
    .rd_a  (raw_a),
    .rd_b  (raw_b)
  );

  always_comb begin
    if (s2_wr && (s2_rd_r == s1_rs_r)) begin
      opa = s2_val_r;
    end else if (s3_wr && (s3_rd_r == s1_rs_r)) begin
      opa = s3_val_r;
    end else if (wb_vld_r && (wb_idx_r == s1_rs_r)) begin
      opa = wb_data;
    end else begin
      opa = raw_a;
    end
    if (s2_wr && (s2_rd_r == s1_rb)) begin
      opb = s2_val_r;
    end else if (s3_wr && (s3_rd_r == s1_rb)) begin
      opb = s3_val_r;
    end else if (wb_vld_r && (wb_idx_r == s1_rb)) begin
      opb = wb_data;
    end else begin
      opb = raw_b;
    end
  end

  assign sum_rr = opa + opb;
  assign sum_ri = opa + s1_imm_r;

  always_comb begin
    s1_val  = opb;
    s1_addr = '0;
    case (s1_op_r)
      OP_ADD:  s1_val = sum_rr;
      OP_ADDI: s1_val = sum_ri;
      OP_LW: begin
        s1_val  = '0;
        s1_addr = sum_ri;
      end
      OP_SW:   s1_addr = sum_ri;
      default: s1_val = opb;
    endcase
  end

  // Word index modulo MEM_WORDS: reciprocal multiply, then quotient back out.
  assign s2_q     = s2_addr_r[XLEN-1:2];
  assign prod_nxt = {{RW{1'b0}}, s2_q} * {{QW{1'b0}}, RECIP_C};
  assign s3_q     = s3_addr_r[XLEN-1:2];
  assign quot     = s3_prod_r[PW-1:SH];
  assign rem      = s3_q - QW'(QW'(quot) * MW_C);

  assign dm_req.rd_en = s3_go && (s3_op_r == OP_LW);
  assign dm_req.wr_en = s3_go && (s3_op_r == OP_SW);
  assign dm_req.wdata = s3_val_r;

  rvme_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dm_req),
    .idx   (rem[AW-1:0]),
    .rdata (dm_rdata),
    .busy  (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      wb_vld_r  <= 1'b0;
    end else begin
      s1_vld_r  <= in_acc || s1_hold;
      s2_vld_r  <= s1_go || (s2_vld_r && !s2_go);
      s3_vld_r  <= s2_go || (s3_vld_r && !s3_go);
      out_vld_r <= s3_go || (out_vld_r && out_stall);
      wb_vld_r  <= s3_go && (s3_op_r != OP_SW);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= op_t'(in_data.opcode);
      s1_rd_r  <= in_data.first_reg;
      s1_rs_r  <= in_data.second_reg;
      s1_rt_r  <= in_data.third_reg;
      s1_imm_r <= in_data.immediate;
    end
    if (s1_go) begin
      s2_op_r   <= s1_op_r;
      s2_rd_r   <= s1_rd_r;
      s2_val_r  <= s1_val;
      s2_addr_r <= s1_addr;
    end
    if (s2_go) begin
      s3_op_r   <= s2_op_r;
      s3_rd_r   <= s2_rd_r;
      s3_val_r  <= s2_val_r;
      s3_addr_r <= s2_addr_r;
      s3_prod_r <= prod_nxt;
    end
    if (s3_go) begin
      out_ld_r   <= (s3_op_r == OP_LW);
      out_st_r   <= (s3_op_r == OP_SW);
      out_val_r  <= s3_val_r;
      out_addr_r <= s3_addr_r;
      wb_ld_r    <= (s3_op_r == OP_LW);
      wb_idx_r   <= s3_rd_r;
      wb_val_r   <= s3_val_r;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_data.result_value = out_ld_r ? dm_rdata : out_val_r;
  assign out_data.mem_address  = out_addr_r;
  assign out_data.did_store    = out_st_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (rem < MW_C))
    else $error("Word index reduction out of range.");

  a_wb_source: assert property (@(posedge clk) disable iff (!rst_n)
    wb_vld_r |-> $past(s3_go && (s3_op_r != OP_SW)))
    else $error("Register write without a retiring writer.");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> (!s1_vld_r && !s2_vld_r && !s3_vld_r && !out_vld_r))
    else $error("Pipeline holds a word during the memory clear.");

  a_load_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && ld_haz && s2_free) |=> !s2_vld_r)
    else $error("Load hazard did not insert a bubble.");

endmodule
